>>> hdl/bmls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button mode LED sequencer package
// Shared constants, configuration register indexes, mode codes and the
// configuration bundle passed from the top level to the tick logic.
// ----------------------------------------------------------------------------
package bmls_pkg;

  localparam int unsigned CFG_WIDTH       = 16;
  localparam int unsigned CFG_INDEX_WIDTH = 3;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RST    = 16'd300;
  localparam logic [CFG_WIDTH-1:0] HOLD_CAP_RST      = 16'd65000;
  localparam logic [CFG_WIDTH-1:0] BLINK_RST         = 16'd10;
  localparam logic [CFG_WIDTH-1:0] PATTERN_ON_RST    = 16'd10;
  localparam logic [CFG_WIDTH-1:0] PATTERN_PERIOD_RST = 16'd100;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_LONG_PRESS     = 3'd0,
    REG_HOLD_CAP       = 3'd1,
    REG_BLINK          = 3'd2,
    REG_PATTERN_ON     = 3'd3,
    REG_PATTERN_PERIOD = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_MANUAL = 2'd1,
    MODE_BLINK  = 2'd2,
    MODE_FLASH  = 2'd3
  } mode_e;

  // Active-low LED pin levels.
  localparam logic LED_LIT  = 1'b0;
  localparam logic LED_DARK = 1'b1;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] long_press_ticks;
    logic [CFG_WIDTH-1:0] hold_count_cap;
    logic [CFG_WIDTH-1:0] blink_ticks;
    logic [CFG_WIDTH-1:0] pattern_on_ticks;
    logic [CFG_WIDTH-1:0] pattern_period_ticks;
  } cfg_t;

endpackage

>>> hdl/bmls_tick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button mode LED sequencer tick logic
// Computes the next sequencer state from the present state, one button
// sample and the configuration. Purely combinational.
// ----------------------------------------------------------------------------
module bmls_tick #(
  parameter int unsigned COUNT_WIDTH = bmls_pkg::COUNT_WIDTH_DEF
) (
  input  bmls_pkg::cfg_t          cfg_i,
  input  logic                    button_level_i,
  input  bmls_pkg::mode_e         mode_i,
  input  logic                    manual_on_i,
  input  logic                    pin_i,
  input  logic                    was_pressed_i,
  input  logic [COUNT_WIDTH-1:0]  hold_i,
  input  logic [COUNT_WIDTH-1:0]  pattern_i,
  output bmls_pkg::mode_e         mode_o,
  output logic                    manual_on_o,
  output logic                    pin_o,
  output logic                    was_pressed_o,
  output logic [COUNT_WIDTH-1:0]  hold_o,
  output logic [COUNT_WIDTH-1:0]  pattern_o
);

  // Compares are done wide enough for both the counters and the registers.
  localparam int unsigned CMP_W =
    (COUNT_WIDTH > bmls_pkg::CFG_WIDTH) ? COUNT_WIDTH : bmls_pkg::CFG_WIDTH;

  logic                   pressed;
  logic [CMP_W-1:0]       hold_ext;
  logic [COUNT_WIDTH-1:0] pat;
  logic [CMP_W-1:0]       pat_ext;

  assign pressed  = ~button_level_i;
  assign hold_ext = CMP_W'(hold_i);

  always_comb begin
    mode_o        = mode_i;
    manual_on_o   = manual_on_i;
    pin_o         = pin_i;
    was_pressed_o = was_pressed_i;
    hold_o        = hold_i;
    pat           = pattern_i;

    if (pressed) begin
      if (!was_pressed_i) begin
        was_pressed_o = 1'b1;
        hold_o        = '0;
      end else if ((hold_ext < CMP_W'(cfg_i.hold_count_cap)) && (hold_i != '1)) begin
        hold_o = hold_i + COUNT_WIDTH'(1);
      end
    end else if (was_pressed_i) begin
      if (hold_ext > CMP_W'(cfg_i.long_press_ticks)) begin
        unique case (mode_i)
          bmls_pkg::MODE_MANUAL: begin
            mode_o = bmls_pkg::MODE_BLINK;
            pin_o  = bmls_pkg::LED_DARK;
          end
          bmls_pkg::MODE_BLINK: begin
            mode_o = bmls_pkg::MODE_FLASH;
            pin_o  = bmls_pkg::LED_LIT;
          end
          default: begin
            mode_o      = bmls_pkg::MODE_MANUAL;
            pin_o       = bmls_pkg::LED_LIT;
            manual_on_o = 1'b1;
          end
        endcase
        pat = '0;
      end else if (mode_i == bmls_pkg::MODE_MANUAL) begin
        // A short press flips the manual LED; the pin is its active-low copy.
        manual_on_o = ~manual_on_i;
        pin_o       = manual_on_i;
      end
      was_pressed_o = 1'b0;
    end

    pat_ext = CMP_W'(pat);
    case (mode_o)
      bmls_pkg::MODE_BLINK: begin
        if (pat_ext >= CMP_W'(cfg_i.blink_ticks)) begin
          pin_o = ~pin_o;
          pat   = '0;
        end
      end
      bmls_pkg::MODE_FLASH: begin
        if (pat_ext == CMP_W'(cfg_i.pattern_on_ticks)) begin
          pin_o = bmls_pkg::LED_DARK;
        end else if (pat_ext >= CMP_W'(cfg_i.pattern_period_ticks)) begin
          pin_o = bmls_pkg::LED_LIT;
          pat   = '0;
        end
      end
      default: begin
      end
    endcase

    pattern_o = pat + COUNT_WIDTH'(1);
  end

endmodule

>>> hdl/button_mode_led_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button mode LED sequencer
// Debounce-free button handling with three LED modes: manual toggle, fast
// blink and short periodic flash, selected by long presses.
// ----------------------------------------------------------------------------
// Each input transfer is one 10 ms tick carrying the raw active-low button
// level, and each produces exactly one result transfer with the LED pin level
// and the active mode. The whole tick update is one pass of compare-and-count
// logic into the state and output registers, so the block takes one tick per
// clock cycle and registers its result; it stalls input only while its output
// register is full and stalled. Configuration writes take effect at the next
// tick and should be made while no transfer is in flight.
// ----------------------------------------------------------------------------
module button_mode_led_sequencer #(
  parameter int unsigned COUNT_WIDTH = bmls_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [bmls_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index_i,
  input  logic [bmls_pkg::CFG_WIDTH-1:0]         cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   button_level_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   led_level_o,
  output logic [1:0]                             current_mode_o
);

  bmls_pkg::cfg_t  cfg_q;

  bmls_pkg::mode_e        mode_q, mode_d;
  logic                   manual_on_q, manual_on_d;
  logic                   pin_q, pin_d;
  logic                   was_pressed_q, was_pressed_d;
  logic [COUNT_WIDTH-1:0] hold_q, hold_d;
  logic [COUNT_WIDTH-1:0] pattern_q, pattern_d;

  logic       out_valid_q;
  logic       led_q;
  logic [1:0] out_mode_q;
  logic       in_xfer;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks     <= bmls_pkg::LONG_PRESS_RST;
      cfg_q.hold_count_cap       <= bmls_pkg::HOLD_CAP_RST;
      cfg_q.blink_ticks          <= bmls_pkg::BLINK_RST;
      cfg_q.pattern_on_ticks     <= bmls_pkg::PATTERN_ON_RST;
      cfg_q.pattern_period_ticks <= bmls_pkg::PATTERN_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (bmls_pkg::cfg_reg_e'(cfg_index_i))
        bmls_pkg::REG_LONG_PRESS:     cfg_q.long_press_ticks     <= cfg_wdata_i;
        bmls_pkg::REG_HOLD_CAP:       cfg_q.hold_count_cap       <= cfg_wdata_i;
        bmls_pkg::REG_BLINK:          cfg_q.blink_ticks          <= cfg_wdata_i;
        bmls_pkg::REG_PATTERN_ON:     cfg_q.pattern_on_ticks     <= cfg_wdata_i;
        bmls_pkg::REG_PATTERN_PERIOD: cfg_q.pattern_period_ticks <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  bmls_tick #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tick (
    .cfg_i          (cfg_q),
    .button_level_i (button_level_i),
    .mode_i         (mode_q),
    .manual_on_i    (manual_on_q),
    .pin_i          (pin_q),
    .was_pressed_i  (was_pressed_q),
    .hold_i         (hold_q),
    .pattern_i      (pattern_q),
    .mode_o         (mode_d),
    .manual_on_o    (manual_on_d),
    .pin_o          (pin_d),
    .was_pressed_o  (was_pressed_d),
    .hold_o         (hold_d),
    .pattern_o      (pattern_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= bmls_pkg::MODE_MANUAL;
      manual_on_q   <= 1'b1;
      pin_q         <= bmls_pkg::LED_LIT;
      was_pressed_q <= 1'b0;
      hold_q        <= '0;
      pattern_q     <= '0;
    end else if (in_xfer) begin
      mode_q        <= mode_d;
      manual_on_q   <= manual_on_d;
      pin_q         <= pin_d;
      was_pressed_q <= was_pressed_d;
      hold_q        <= hold_d;
      pattern_q     <= pattern_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      led_q      <= pin_d;
      out_mode_q <= mode_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign led_level_o    = led_q;
  assign current_mode_o = out_mode_q;

endmodule

>>> verif/tb_button_mode_led_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button mode LED sequencer testbench
// Drives button ticks with random gaps and output stalls. A scoreboard class
// predicts the LED level and mode for every tick and compares them in order
// with the results. The configuration changes between phases while the block
// is idle.
// ----------------------------------------------------------------------------
module tb_button_mode_led_sequencer;

  localparam logic        BTN_PRESSED    = 1'b0;
  localparam logic        BTN_RELEASED   = 1'b1;
  localparam int unsigned MAX_WAIT       = 17;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES  = 11;
  localparam int unsigned PHASE_TICKS    = 102;

  class led_tick_scoreboard;
    typedef struct packed {
      logic            led;
      bmls_pkg::mode_e mode;
    } tick_result_t;

    logic [bmls_pkg::CFG_WIDTH-1:0] long_press_ticks;
    logic [bmls_pkg::CFG_WIDTH-1:0] hold_cap;
    logic [bmls_pkg::CFG_WIDTH-1:0] blink_ticks;
    logic [bmls_pkg::CFG_WIDTH-1:0] on_ticks;
    logic [bmls_pkg::CFG_WIDTH-1:0] period_ticks;

    bmls_pkg::mode_e                mode;
    logic                           manual_on;
    logic                           pin;
    logic                           was_pressed;
    logic [bmls_pkg::CFG_WIDTH-1:0] hold_count;
    logic [bmls_pkg::CFG_WIDTH-1:0] pattern_count;

    tick_result_t                   expected_q[$];
    int unsigned                    errors;

    function new();
      long_press_ticks = bmls_pkg::LONG_PRESS_RST;
      hold_cap         = bmls_pkg::HOLD_CAP_RST;
      blink_ticks      = bmls_pkg::BLINK_RST;
      on_ticks         = bmls_pkg::PATTERN_ON_RST;
      period_ticks     = bmls_pkg::PATTERN_PERIOD_RST;
      mode             = bmls_pkg::MODE_MANUAL;
      manual_on        = 1'b1;
      pin              = bmls_pkg::LED_LIT;
      was_pressed      = 1'b0;
      hold_count       = '0;
      pattern_count    = '0;
      errors           = 0;
    endfunction

    function void apply_reg_write(logic [bmls_pkg::CFG_INDEX_WIDTH-1:0] index,
                                  logic [bmls_pkg::CFG_WIDTH-1:0] data);
      case (index)
        bmls_pkg::REG_LONG_PRESS:     long_press_ticks = data;
        bmls_pkg::REG_HOLD_CAP:       hold_cap = data;
        bmls_pkg::REG_BLINK:          blink_ticks = data;
        bmls_pkg::REG_PATTERN_ON:     on_ticks = data;
        bmls_pkg::REG_PATTERN_PERIOD: period_ticks = data;
        default: ;
      endcase
    endfunction

    function void predict_tick(logic level);
      if (level == BTN_PRESSED) begin
        // The first pressed tick only arms the hold counter.
        if (!was_pressed) begin
          was_pressed = 1'b1;
          hold_count  = '0;
        end else if (hold_count < hold_cap && hold_count != '1) begin
          hold_count = hold_count + bmls_pkg::CFG_WIDTH'(1);
        end
      end else if (was_pressed) begin
        if (hold_count > long_press_ticks) begin
          case (mode)
            bmls_pkg::MODE_MANUAL: mode = bmls_pkg::MODE_BLINK;
            bmls_pkg::MODE_BLINK:  mode = bmls_pkg::MODE_FLASH;
            default:               mode = bmls_pkg::MODE_MANUAL;
          endcase
          case (mode)
            bmls_pkg::MODE_MANUAL: begin
              pin       = bmls_pkg::LED_LIT;
              manual_on = 1'b1;
            end
            bmls_pkg::MODE_BLINK: pin = bmls_pkg::LED_DARK;
            default:              pin = bmls_pkg::LED_LIT;
          endcase
          pattern_count = '0;
        end else if (mode == bmls_pkg::MODE_MANUAL) begin
          manual_on = ~manual_on;
          pin       = manual_on ? bmls_pkg::LED_LIT : bmls_pkg::LED_DARK;
        end
        was_pressed = 1'b0;
      end

      if (mode == bmls_pkg::MODE_BLINK) begin
        if (pattern_count >= blink_ticks) begin
          pin           = ~pin;
          pattern_count = '0;
        end
      end else if (mode == bmls_pkg::MODE_FLASH) begin
        // The off compare wins over the end of the period.
        if (pattern_count == on_ticks) begin
          pin = bmls_pkg::LED_DARK;
        end else if (pattern_count >= period_ticks) begin
          pin           = bmls_pkg::LED_LIT;
          pattern_count = '0;
        end
      end
      pattern_count = pattern_count + bmls_pkg::CFG_WIDTH'(1);

      expected_q.push_back('{led: pin, mode: mode});
    endfunction

    function void check_tick_result(logic led, logic [1:0] mode_seen);
      tick_result_t exp_result;
      if (expected_q.size() == 0) begin
        $error("unexpected result: led_level %0d current_mode %0d", led, mode_seen);
        errors++;
        return;
      end
      exp_result = expected_q.pop_front();
      if (exp_result.led !== led) begin
        $error("led_level: expected %0d, actual %0d", exp_result.led, led);
        errors++;
      end
      if (exp_result.mode !== mode_seen) begin
        $error("current_mode: expected %0d, actual %0d", exp_result.mode, mode_seen);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                                 clk_i          = 1'b0;
  logic                                 rst_ni         = 1'b0;
  logic                                 cfg_we_i       = 1'b0;
  logic [bmls_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i    = '0;
  logic [bmls_pkg::CFG_WIDTH-1:0]       cfg_wdata_i    = '0;
  logic                                 in_valid_i     = 1'b0;
  logic                                 in_stall_o;
  logic                                 button_level_i = BTN_RELEASED;
  logic                                 out_valid_o;
  logic                                 out_stall_i    = 1'b0;
  logic                                 led_level_o;
  logic [1:0]                           current_mode_o;

  led_tick_scoreboard sb;
  bit                 no_idle    = 1'b0;
  int unsigned        ticks_sent = 0;
  int unsigned        idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  button_mode_led_sequencer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .button_level_i (button_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .led_level_o    (led_level_o),
    .current_mode_o (current_mode_o)
  );

  // Result checking and the watchdog on transfers of either side.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      sb.check_tick_result(led_level_o, current_mode_o);
    end
    if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("FAIL button_mode_led_sequencer");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // After each result transfer the receiver may hold off the next one.
  initial begin
    int unsigned hold;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        hold = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (hold != 0) begin
          out_stall_i <= 1'b1;
          repeat (hold) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  task automatic send_tick(logic level);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    button_level_i <= level;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.predict_tick(level);
    ticks_sent++;
  endtask

  // Holds the button so that the hold counter reaches held, then releases it.
  task automatic press_and_release(int unsigned held);
    repeat (held + 1) send_tick(BTN_PRESSED);
    send_tick(BTN_RELEASED);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [bmls_pkg::CFG_INDEX_WIDTH-1:0] index,
                           logic [bmls_pkg::CFG_WIDTH-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.apply_reg_write(index, data);
  endtask

  // The unmapped write comes last so that any aliasing would corrupt a setting.
  task automatic load_settings(logic [bmls_pkg::CFG_WIDTH-1:0] long_v,
                               logic [bmls_pkg::CFG_WIDTH-1:0] cap_v,
                               logic [bmls_pkg::CFG_WIDTH-1:0] blink_v,
                               logic [bmls_pkg::CFG_WIDTH-1:0] on_v,
                               logic [bmls_pkg::CFG_WIDTH-1:0] period_v);
    write_reg(bmls_pkg::REG_LONG_PRESS, long_v);
    write_reg(bmls_pkg::REG_HOLD_CAP, cap_v);
    write_reg(bmls_pkg::REG_BLINK, blink_v);
    write_reg(bmls_pkg::REG_PATTERN_ON, on_v);
    write_reg(bmls_pkg::REG_PATTERN_PERIOD, period_v);
    write_reg(bmls_pkg::CFG_INDEX_WIDTH'($urandom_range(bmls_pkg::REG_PATTERN_PERIOD + 1,
                                         (1 << bmls_pkg::CFG_INDEX_WIDTH) - 1)),
              bmls_pkg::CFG_WIDTH'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [bmls_pkg::CFG_WIDTH-1:0] draw_setting();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return bmls_pkg::CFG_WIDTH'(1);
      8, 9:    return bmls_pkg::CFG_WIDTH'($urandom);
      default: return bmls_pkg::CFG_WIDTH'($urandom_range(1, 24));
    endcase
  endfunction

  // Mostly complete presses of random length, with some raw noise in between.
  task automatic run_random_phase(int unsigned n_ticks);
    int unsigned stop_at;
    int unsigned run;
    int unsigned held;
    int unsigned long_ticks;
    stop_at    = ticks_sent + n_ticks;
    long_ticks = 32'(sb.long_press_ticks);
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 9) < 2) begin
        run = $urandom_range(1, 6);
        repeat (run) send_tick(1'($urandom_range(0, 1)));
      end else begin
        run = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
        repeat (run) send_tick(BTN_RELEASED);
        if (long_ticks < 40 && $urandom_range(0, 1) == 1) begin
          held = long_ticks + 1 + $urandom_range(0, 3);
        end else begin
          held = $urandom_range(0, (long_ticks < 20) ? long_ticks : 20);
        end
        press_and_release(held);
      end
    end
  endtask

  initial begin
    int unsigned phase;
    logic [bmls_pkg::CFG_WIDTH-1:0] long_v;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: a single-tick press toggles the LED off in manual mode.
    send_tick(BTN_RELEASED);
    press_and_release(0);
    wait_idle();

    // Zero thresholds: blink toggles every tick, flash compares against zero.
    load_settings(bmls_pkg::CFG_WIDTH'(1), '1, '0, '0, '0);
    press_and_release(2);
    send_tick(BTN_RELEASED);
    press_and_release(0);
    press_and_release(2);
    send_tick(BTN_RELEASED);
    press_and_release(2);
    wait_idle();

    // A saturated hold counter cannot exceed the threshold.
    load_settings(bmls_pkg::CFG_WIDTH'(1), bmls_pkg::CFG_WIDTH'(1),
                  bmls_pkg::CFG_WIDTH'(1), bmls_pkg::CFG_WIDTH'(1),
                  bmls_pkg::CFG_WIDTH'(1));
    press_and_release(3);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      no_idle = (phase % 4 == 3);
      if (phase == 0) begin
        load_settings('0, '1, '1, '1, '1);
      end else if (phase == 1) begin
        load_settings('1, '0, bmls_pkg::CFG_WIDTH'(1), bmls_pkg::CFG_WIDTH'(1),
                      bmls_pkg::CFG_WIDTH'(1));
      end else begin
        long_v = ($urandom_range(0, 4) != 0) ? bmls_pkg::CFG_WIDTH'($urandom_range(0, 12))
                                             : draw_setting();
        load_settings(long_v, draw_setting(), draw_setting(), draw_setting(),
                      draw_setting());
      end
      run_random_phase(PHASE_TICKS);
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS button_mode_led_sequencer");
    end else begin
      $display("FAIL button_mode_led_sequencer");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/bmls_pkg.sv
hdl/bmls_tick.sv
hdl/button_mode_led_sequencer.sv
verif/tb_button_mode_led_sequencer.sv
